>>> sv/wasm_loop_guard_checker_core_macros.svh
// Assertion helpers for the loop guard checker
`ifndef WASM_LOOP_GUARD_CHECKER_CORE_MACROS_SVH
`define WASM_LOOP_GUARD_CHECKER_CORE_MACROS_SVH

// implication checked on every rising edge outside reset
`define WLG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define WLG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/wlg_pkg.sv
package wlg_pkg;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [15:0] fail_offset;
  } out_item_t;

  // byte tagged with its position in the body
  typedef struct packed {
    logic [7:0]  code_byte;
    logic        last_byte;
    logic [15:0] pos;
  } tagged_item_t;

  typedef struct packed {
    logic        ful;
    logic        empty;
    logic [1:0]  count;
  } queue_status_t;

  localparam logic [2:0] V_OK        = 3'd0;
  localparam logic [2:0] V_FEW_ARGS  = 3'd1;
  localparam logic [2:0] V_ARG_ZERO  = 3'd2;
  localparam logic [2:0] V_BRANCH    = 3'd3;
  localparam logic [2:0] V_MEM_GROW  = 3'd4;
  localparam logic [2:0] V_MISSING   = 3'd5;
  localparam logic [2:0] V_TRUNCATED = 3'd6;
  localparam logic [2:0] V_MAP_FULL  = 3'd7;

  localparam logic [7:0] OP_BLOCK    = 8'h02;
  localparam logic [7:0] OP_LOOP     = 8'h03;
  localparam logic [7:0] OP_IF       = 8'h04;
  localparam logic [7:0] OP_END      = 8'h0B;
  localparam logic [7:0] OP_BR       = 8'h0C;
  localparam logic [7:0] OP_BR_IF    = 8'h0D;
  localparam logic [7:0] OP_BR_TABLE = 8'h0E;
  localparam logic [7:0] OP_CALL     = 8'h10;
  localparam logic [7:0] OP_CALL_IND = 8'h11;
  localparam logic [7:0] OP_LGET     = 8'h20;
  localparam logic [7:0] OP_LSET     = 8'h21;
  localparam logic [7:0] OP_LTEE     = 8'h22;
  localparam logic [7:0] OP_GGET     = 8'h23;
  localparam logic [7:0] OP_GSET     = 8'h24;
  localparam logic [7:0] OP_MEM_SIZE = 8'h3F;
  localparam logic [7:0] OP_MEM_GROW = 8'h40;
  localparam logic [7:0] OP_I32      = 8'h41;
  localparam logic [7:0] OP_I64      = 8'h42;
  localparam logic [7:0] OP_F32      = 8'h43;
  localparam logic [7:0] OP_F64      = 8'h44;
  localparam logic [7:0] OP_PREFIX   = 8'hFC;

endpackage

>>> sv/wlg_front.sv
// Tags each accepted byte with its saturating body position.
module wlg_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  wlg_pkg::in_item_t     in_data,
  output logic                  push,
  output wlg_pkg::tagged_item_t push_data,
  input  wlg_pkg::queue_status_t qstat
);
  logic [15:0] pos_r, pos_nxt;

  assign in_stall = qstat.ful;
  assign push     = in_valid && !qstat.ful;

  always_comb begin
    push_data.code_byte = in_data.code_byte;
    push_data.last_byte = in_data.last_byte;
    push_data.pos       = pos_r;
    pos_nxt = pos_r;
    if (push) begin
      if (in_data.last_byte) pos_nxt = '0;
      else if (pos_r != 16'hFFFF) pos_nxt = pos_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pos_r <= '0;
    else pos_r <= pos_nxt;
  end
endmodule

>>> sv/wlg_queue.sv
// Two-entry queue between front and back.
module wlg_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  wlg_pkg::tagged_item_t  push_data,
  input  logic                   pop,
  output wlg_pkg::tagged_item_t  head,
  output wlg_pkg::queue_status_t qstat
);
  wlg_pkg::tagged_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign head        = mem_r[rp_r];
  assign qstat.count = cnt_r;
  assign qstat.empty = (cnt_r == 2'd0);
  assign qstat.ful   = (cnt_r == 2'd2);

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> sv/wlg_back.sv
// Decoder, value stack and index maps; one byte per cycle unless the queue is empty or the output stalls.
module wlg_back #(
  parameter int STACK_DEPTH = 16,
  parameter int MAP_ENTRIES = 16,
  parameter int DEPTH_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [31:0]            guard_idx,
  input  wlg_pkg::tagged_item_t  head,
  input  wlg_pkg::queue_status_t qstat,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output wlg_pkg::out_item_t     out_data
);
  localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SC_W = $clog2(STACK_DEPTH + 1);
  localparam int MI_W = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

  typedef enum logic [5:0] {
    PH_OP    = 6'b000001,
    PH_SKIP  = 6'b000010,
    PH_LEB   = 6'b000100,
    PH_LEB2  = 6'b001000,
    PH_TABLE = 6'b010000,
    PH_LAST  = 6'b100000
  } phase_t;

  phase_t            ph_r, ph_nxt;
  logic              srch_r, srch_nxt;
  logic [DEPTH_BITS-1:0] dep_r, dep_nxt;
  logic [63:0]       stk_r [STACK_DEPTH];
  logic [SP_W-1:0]   snext_r, snext_nxt;
  logic [SC_W-1:0]   scnt_r, scnt_nxt;
  logic [MAP_ENTRIES-1:0] lv_r, lv_nxt, gv_r, gv_nxt;
  logic [31:0]       lk_r [MAP_ENTRIES];
  logic [63:0]       lval_r [MAP_ENTRIES];
  logic [31:0]       gk_r [MAP_ENTRIES];
  logic [63:0]       gval_r [MAP_ENTRIES];
  logic [63:0]       acc_r, acc_nxt;
  logic [6:0]        sh_r, sh_nxt;
  logic [7:0]        pop_r, pop_nxt;
  logic [3:0]        skip_r, skip_nxt;
  logic [31:0]       tbl_r, tbl_nxt;
  logic              vg_r, vg_nxt;
  logic              ov_r;
  wlg_pkg::out_item_t od_r;

  // stack / map write controls
  logic              spush, mwr, mglob;
  logic [63:0]       spush_val, mwr_val;
  logic [MI_W-1:0]   mwr_idx;

  logic [7:0]  b;
  logic        go, have_v;
  logic [2:0]  vcode;
  logic [63:0] top, second, leb_v, mval;
  logic [31:0] idx;
  logic        hit, free_ok;
  logic [MI_W-1:0] hit_i, free_i;
  logic        use_g;

  // ring pointer steps modulo STACK_DEPTH
  function automatic logic [SP_W-1:0] sp_back(input logic [SP_W-1:0] p,
                                               input logic [1:0] n);
    logic [SP_W:0] t;
    t = {1'b0, p} + (SP_W+1)'(STACK_DEPTH) - (SP_W+1)'(n);
    if (t >= (SP_W+1)'(STACK_DEPTH)) t = t - (SP_W+1)'(STACK_DEPTH);
    return t[SP_W-1:0];
  endfunction

  function automatic logic [SP_W-1:0] sp_fwd(input logic [SP_W-1:0] p);
    logic [SP_W:0] t;
    t = {1'b0, p} + (SP_W+1)'(1);
    if (t >= (SP_W+1)'(STACK_DEPTH)) t = '0;
    return t[SP_W-1:0];
  endfunction

  assign b   = head.code_byte;
  assign go  = !qstat.empty && !(ov_r && out_stall);
  assign pop = go;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  assign top    = (scnt_r == '0) ? 64'd0 : stk_r[sp_back(snext_r, 2'd1)];
  assign second = (scnt_r < SC_W'(2)) ? 64'd0 : stk_r[sp_back(snext_r, 2'd2)];
  assign leb_v  = (sh_r < 7'd64) ? (acc_r | ({57'd0, b[6:0]} << sh_r[5:0])) : acc_r;
  assign idx    = leb_v[31:0];
  assign use_g  = (pop_r == wlg_pkg::OP_GGET) || (pop_r == wlg_pkg::OP_GSET);

  // parallel map lookup
  always_comb begin
    hit = 1'b0; hit_i = '0; free_ok = 1'b0; free_i = '0; mval = 64'd0;
    for (int i = MAP_ENTRIES - 1; i >= 0; i--) begin
      if (use_g ? (gv_r[i] && gk_r[i] == idx) : (lv_r[i] && lk_r[i] == idx)) begin
        hit = 1'b1; hit_i = MI_W'(i);
        mval = use_g ? gval_r[i] : lval_r[i];
      end
      if (!(use_g ? gv_r[i] : lv_r[i])) begin
        free_ok = 1'b1; free_i = MI_W'(i);
      end
    end
  end

  task automatic do_push(input logic [63:0] v);
    spush = 1'b1; spush_val = v;
    snext_nxt = sp_fwd(snext_nxt);
    if (scnt_nxt < SC_W'(STACK_DEPTH)) scnt_nxt = scnt_nxt + SC_W'(1);
  endtask

  always_comb begin
    ph_nxt = ph_r; srch_nxt = srch_r; dep_nxt = dep_r; snext_nxt = snext_r;
    scnt_nxt = scnt_r; lv_nxt = lv_r; gv_nxt = gv_r; acc_nxt = acc_r;
    sh_nxt = sh_r; pop_nxt = pop_r; skip_nxt = skip_r; tbl_nxt = tbl_r;
    vg_nxt = vg_r; have_v = 1'b0; vcode = wlg_pkg::V_OK;
    spush = 1'b0; spush_val = 64'd0; mwr = 1'b0; mwr_val = 64'd0;
    mwr_idx = '0; mglob = 1'b0;
    if (go && !vg_r) begin
      unique case (ph_r)
        PH_OP: begin
          pop_nxt = b;
          if (b == wlg_pkg::OP_CALL || b == wlg_pkg::OP_CALL_IND) ph_nxt = PH_LEB;
          else if (b >= 8'h02 && b <= 8'h0F) begin
            if (srch_r) begin
              have_v = 1'b1; vcode = wlg_pkg::V_BRANCH;
            end else if (b == wlg_pkg::OP_BLOCK || b == wlg_pkg::OP_LOOP ||
                         b == wlg_pkg::OP_IF) begin
              ph_nxt = PH_SKIP; skip_nxt = 4'd1;
            end else if (b == wlg_pkg::OP_BR || b == wlg_pkg::OP_BR_IF ||
                         b == wlg_pkg::OP_BR_TABLE) ph_nxt = PH_LEB;
            else if (b == wlg_pkg::OP_END) begin
              if (dep_r == '0) begin
                have_v = 1'b1; vcode = wlg_pkg::V_OK;
              end else dep_nxt = dep_r - DEPTH_BITS'(1);
            end
          end else if ((b >= wlg_pkg::OP_LGET && b <= wlg_pkg::OP_GSET) ||
                       (b >= 8'h28 && b <= 8'h3E) || b == wlg_pkg::OP_I32 ||
                       b == wlg_pkg::OP_I64) ph_nxt = PH_LEB;
          else if (b == wlg_pkg::OP_MEM_SIZE || b == wlg_pkg::OP_MEM_GROW ||
                   b == wlg_pkg::OP_PREFIX) begin
            ph_nxt = PH_SKIP; skip_nxt = 4'd1;
          end else if (b == wlg_pkg::OP_F32) begin
            ph_nxt = PH_SKIP; skip_nxt = 4'd4;
          end else if (b == wlg_pkg::OP_F64) begin
            ph_nxt = PH_SKIP; skip_nxt = 4'd8;
          end
        end
        PH_SKIP: begin
          if (skip_r != 4'd0) skip_nxt = skip_r - 4'd1;
          if (skip_r <= 4'd1) begin
            ph_nxt = PH_OP;
            if (pop_r == wlg_pkg::OP_MEM_GROW) begin
              have_v = 1'b1; vcode = wlg_pkg::V_MEM_GROW;
            end else if (pop_r == wlg_pkg::OP_PREFIX) ph_nxt = PH_LEB;
            else if (pop_r == wlg_pkg::OP_BLOCK || pop_r == wlg_pkg::OP_LOOP ||
                     pop_r == wlg_pkg::OP_IF) begin
              if (dep_r != '1) dep_nxt = dep_r + DEPTH_BITS'(1);
              if (pop_r == wlg_pkg::OP_LOOP) srch_nxt = 1'b1;
            end
          end
        end
        PH_LEB, PH_LEB2, PH_TABLE, PH_LAST: begin
          acc_nxt = leb_v;
          if (sh_r < 7'd70) sh_nxt = sh_r + 7'd7;
          if (!b[7]) begin
            acc_nxt = 64'd0; sh_nxt = 7'd0; ph_nxt = PH_OP;
            if (pop_r == wlg_pkg::OP_CALL) begin
              if (idx == guard_idx && srch_r) begin
                if (scnt_r < SC_W'(2)) begin
                  have_v = 1'b1; vcode = wlg_pkg::V_FEW_ARGS;
                end else if (second == 64'd0) begin
                  have_v = 1'b1; vcode = wlg_pkg::V_ARG_ZERO;
                  snext_nxt = sp_back(snext_r, 2'd2);
                  scnt_nxt = scnt_r - SC_W'(2);
                end else begin
                  scnt_nxt = '0; snext_nxt = '0;
                  lv_nxt = '0; gv_nxt = '0; srch_nxt = 1'b0;
                end
              end
            end else if (pop_r == wlg_pkg::OP_CALL_IND) begin
              ph_nxt = PH_SKIP; skip_nxt = 4'd1;
            end else if (pop_r == wlg_pkg::OP_BR_TABLE) begin
              if (ph_r == PH_LEB) begin
                tbl_nxt = idx;
                ph_nxt = (idx != 32'd0) ? PH_TABLE : PH_LAST;
              end else if (ph_r == PH_TABLE) begin
                tbl_nxt = tbl_r - 32'd1;
                ph_nxt = (tbl_r != 32'd1) ? PH_TABLE : PH_LAST;
              end
            end else if (pop_r >= wlg_pkg::OP_LGET && pop_r <= wlg_pkg::OP_GSET) begin
              if (srch_r) begin
                if (pop_r == wlg_pkg::OP_LGET || pop_r == wlg_pkg::OP_GGET) begin
                  do_push(hit ? mval : 64'd0);
                end else if (!hit && !free_ok) begin
                  have_v = 1'b1; vcode = wlg_pkg::V_MAP_FULL;
                end else begin
                  mwr = 1'b1; mglob = use_g; mwr_val = top;
                  mwr_idx = hit ? hit_i : free_i;
                  if (use_g) gv_nxt[mwr_idx] = 1'b1;
                  else lv_nxt[mwr_idx] = 1'b1;
                  if (pop_r != wlg_pkg::OP_LTEE && scnt_r != '0) begin
                    snext_nxt = sp_back(snext_r, 2'd1);
                    scnt_nxt = scnt_r - SC_W'(1);
                  end
                end
              end
            end else if (pop_r >= 8'h28 && pop_r <= 8'h3E) begin
              if (ph_r == PH_LEB) ph_nxt = PH_LEB2;
            end else if (pop_r == wlg_pkg::OP_I32 || pop_r == wlg_pkg::OP_I64) begin
              do_push(leb_v);
            end
          end
        end
        default: ph_nxt = PH_OP;
      endcase
      if (!have_v && head.last_byte) begin
        have_v = 1'b1;
        if (ph_nxt != PH_OP) vcode = wlg_pkg::V_TRUNCATED;
        else vcode = srch_nxt ? wlg_pkg::V_MISSING : wlg_pkg::V_OK;
      end
      if (have_v) vg_nxt = 1'b1;
    end
    if (go && head.last_byte) begin
      ph_nxt = PH_OP; srch_nxt = 1'b0; dep_nxt = '0; snext_nxt = '0;
      scnt_nxt = '0; lv_nxt = '0; gv_nxt = '0; acc_nxt = 64'd0; sh_nxt = 7'd0;
      pop_nxt = 8'd0; skip_nxt = 4'd0; tbl_nxt = 32'd0; vg_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (spush) stk_r[snext_r] <= spush_val;
    if (mwr && !mglob) begin
      lk_r[mwr_idx] <= idx; lval_r[mwr_idx] <= mwr_val;
    end
    if (mwr && mglob) begin
      gk_r[mwr_idx] <= idx; gval_r[mwr_idx] <= mwr_val;
    end
    if (go && have_v) begin
      od_r.verdict     <= vcode;
      od_r.fail_offset <= head.pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_OP; srch_r <= 1'b0; dep_r <= '0; snext_r <= '0; scnt_r <= '0;
      lv_r <= '0; gv_r <= '0; acc_r <= 64'd0; sh_r <= 7'd0; pop_r <= 8'd0;
      skip_r <= 4'd0; tbl_r <= 32'd0; vg_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt; srch_r <= srch_nxt; dep_r <= dep_nxt; snext_r <= snext_nxt;
      scnt_r <= scnt_nxt; lv_r <= lv_nxt; gv_r <= gv_nxt; acc_r <= acc_nxt;
      sh_r <= sh_nxt; pop_r <= pop_nxt; skip_r <= skip_nxt; tbl_r <= tbl_nxt;
      vg_r <= vg_nxt;
      if (go && have_v) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end
endmodule

>>> sv/wasm_loop_guard_checker_core.sv
// Loop guard checker: scans one wasm function body per pass, byte by byte.
// Input channel in_valid/in_stall/in_data carries code_byte and last_byte;
// last_byte closes a body. Output channel out_valid/out_stall/out_data gives
// exactly one verdict item per body with the offset of the deciding byte.
// cfg_we/cfg_wdata write the guard function index; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Throughput: one byte per cycle while the queue holds a byte and the output
// is not stalled; the back end decodes, updates the value stack and compares
// against all map entries in parallel. A byte's verdict passes through the
// two-entry queue and the output register. A stalled output holds its item;
// the back end then stops and the queue fills, after which in_stall rises.
// Bytes after a verdict are consumed silently until last_byte. Synchronous
// reset clears parser state, the queue, the guard index and output valid.
`include "wasm_loop_guard_checker_core_macros.svh"
module wasm_loop_guard_checker_core #(
  parameter int STACK_DEPTH = 16,
  parameter int MAP_ENTRIES = 16,
  parameter int DEPTH_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wlg_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wlg_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);
  logic [31:0] guard_r;
  logic push, pop;
  wlg_pkg::tagged_item_t push_data, head;
  wlg_pkg::queue_status_t qstat;

  always_ff @(posedge clk) begin
    if (!rst_n) guard_r <= 32'd0;
    else if (cfg_we) guard_r <= cfg_wdata;
  end

  wlg_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .push, .push_data, .qstat
  );

  wlg_queue u_queue (
    .clk, .rst_n, .push, .push_data, .pop, .head, .qstat
  );

  wlg_back #(
    .STACK_DEPTH(STACK_DEPTH), .MAP_ENTRIES(MAP_ENTRIES), .DEPTH_BITS(DEPTH_BITS)
  ) u_back (
    .clk, .rst_n, .guard_idx(guard_r), .head, .qstat, .pop,
    .out_valid, .out_stall, .out_data
  );

  `WLG_ASSERT_IMPL(a_no_pop_empty, pop, !qstat.empty, "pop from empty queue")
  `WLG_ASSERT_IMPL(a_cnt_range, 1'b1, qstat.count != 2'd3, "queue count overflow")
  `WLG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data),
    "stalled verdict changed")
endmodule
